### design/tcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_pkg: shared types and constants of the tilt complementary filter
// Sequencer states, configuration bundle, angle limits and the CORDIC
// arctangent table in 1/65536 degree units.
// ----------------------------------------------------------------------------
package tcf_pkg;

  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned MAX_STEPS = 24;

  // register indexes, taken from paddr[2]
  localparam logic REG_IDX_WEIGHT = 1'b0;
  localparam logic REG_IDX_PERIOD = 1'b1;

  localparam logic [15:0] WEIGHT_RESET = 16'd328;
  localparam logic [15:0] PERIOD_RESET = 16'd328;

  // 180 and 90 degrees in 1/65536 degree
  localparam logic signed [26:0] ANGLE_LIMIT = 27'sd11796480;
  localparam logic signed [24:0] DEG90       = 25'sd5898240;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_GYRO,
    ST_WAIT,
    ST_FUSE,
    ST_SUM,
    ST_OUT
  } tcf_state_e;

  typedef enum logic [1:0] {
    COR_IDLE,
    COR_RUN,
    COR_FIN
  } cor_state_e;

  typedef struct packed {
    logic [15:0] accel_weight;
    logic [15:0] sample_period;
  } tcf_cfg_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_lut(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

### design/tilt_complementary_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_complementary_filter_top: IMU tilt complementary filter
// Fuses integrated gyro rate with a CORDIC accelerometer tilt angle.
// ----------------------------------------------------------------------------
// One raw sample (accel Y, accel Z, gyro X) enters per transaction and yields
// one result: the fused tilt angle and the two-sample mean rate, both in
// 1/256 degree units. A sample passes from acceptance through the states INC,
// GYRO, WAIT, FUSE, SUM and OUT to the output register; WAIT lasts while the
// CORDIC loop runs, which performs one micro-rotation per cycle with the step
// count capped at 24; a sample with zero Y or zero Z skips the rotations. With
// the output register free, the next sample can be taken in the cycle after the
// result is loaded. The gyro
// increment and the fusion share one registered multiplier. s_axis_tready is
// high only while the sequencer is idle; a finished result waits in the output
// register while the next sample is taken in. accel_weight (address 0) and
// sample_period (address 4) are Q0.16 and must be written while idle.
module tilt_complementary_filter_top #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // accel_y[15:0], accel_z[31:16], gyro_x[47:32]
  input  logic [47:0]                s_axis_tdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // tilt_angle[16:0], tilt_rate[34:17], zero pad[39:35]
  output logic [39:0]                m_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  tcf_pkg::tcf_state_e state_q, state_d;
  tcf_pkg::tcf_cfg_t   cfg;

  logic signed [15:0] ay_q, az_q, prev_q;
  logic signed [23:0] neg_g_q;
  logic signed [17:0] rate_q;
  logic signed [26:0] gyro_q, diff_q;
  logic signed [24:0] acc_q;
  logic               out_valid_q;
  logic [39:0]        out_data_q;

  logic               in_fire, out_free, load_out;
  logic signed [15:0] g_in;
  logic signed [24:0] rate_full, g_sum;
  logic signed [23:0] g_in24;
  logic signed [27:0] mul_a;
  logic        [15:0] mul_b;
  logic signed [44:0] prod, prod_inc, prod_fuse;
  logic signed [26:0] fused, fused_sat;
  logic signed [24:0] tilt_full;
  logic               cor_start, cor_busy;
  logic signed [23:0] cor_angle;

  tcf_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  tcf_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cor_start),
    .accel_y_i(ay_q),
    .accel_z_i(az_q),
    .busy_o   (cor_busy),
    .angle_o  (cor_angle)
  );

  tcf_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  assign s_axis_tready = state_q == tcf_pkg::ST_IDLE;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign load_out      = (state_q == tcf_pkg::ST_OUT) && out_free;

  assign g_in   = s_axis_tdata[47:32];
  assign g_in24 = 24'(g_in);
  // rate = -(g + prev) * 125 / 64, rounded
  assign g_sum     = 25'(g_in) + 25'(prev_q);
  assign rate_full = 25'(-(g_sum * 25'sd125)) + 25'sd32;

  // rounded shifts of the shared product
  assign prod_inc  = prod + 45'sd4096;
  assign prod_fuse = prod + 45'sd32768;
  assign fused     = gyro_q + prod_fuse[42:16];

  always_comb begin
    if (fused > tcf_pkg::ANGLE_LIMIT) begin
      fused_sat = tcf_pkg::ANGLE_LIMIT;
    end else if (fused < -tcf_pkg::ANGLE_LIMIT) begin
      fused_sat = -tcf_pkg::ANGLE_LIMIT;
    end else begin
      fused_sat = fused;
    end
  end

  assign tilt_full = acc_q + 25'sd128;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcf_pkg::ST_IDLE: if (in_fire) state_d = tcf_pkg::ST_INC;
      tcf_pkg::ST_INC:  state_d = tcf_pkg::ST_GYRO;
      tcf_pkg::ST_GYRO: state_d = tcf_pkg::ST_WAIT;
      tcf_pkg::ST_WAIT: if (!cor_busy) state_d = tcf_pkg::ST_FUSE;
      tcf_pkg::ST_FUSE: state_d = tcf_pkg::ST_SUM;
      tcf_pkg::ST_SUM:  state_d = tcf_pkg::ST_OUT;
      tcf_pkg::ST_OUT:  if (out_free) state_d = tcf_pkg::ST_IDLE;
      default:          state_d = tcf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cor_start = 1'b0;
    mul_a     = 28'(neg_g_q);
    mul_b     = cfg.sample_period;
    case (state_q)
      tcf_pkg::ST_INC: begin
        cor_start = 1'b1;
      end
      tcf_pkg::ST_FUSE: begin
        mul_a = 28'(diff_q);
        mul_b = cfg.accel_weight;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcf_pkg::ST_IDLE;
      prev_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) prev_q <= g_in;
      if (state_q == tcf_pkg::ST_SUM) acc_q <= fused_sat[24:0];
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ay_q    <= s_axis_tdata[15:0];
      az_q    <= s_axis_tdata[31:16];
      neg_g_q <= 24'(-(g_in24 * 24'sd125));
      rate_q  <= rate_full[23:6];
    end
    if (state_q == tcf_pkg::ST_GYRO) gyro_q <= 27'(acc_q) + prod_inc[39:13];
    if (state_q == tcf_pkg::ST_WAIT) diff_q <= 27'(cor_angle) - gyro_q;
    if (load_out) out_data_q <= {5'd0, rate_q, tilt_full[24:8]};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### design/tcf_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_regs: configuration register file
// APB-style slave holding the accelerometer weight and the sample period.
// ----------------------------------------------------------------------------
module tcf_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output tcf_pkg::tcf_cfg_t          cfg_o
);

  tcf_pkg::tcf_cfg_t cfg_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_weight  <= tcf_pkg::WEIGHT_RESET;
      cfg_q.sample_period <= tcf_pkg::PERIOD_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        tcf_pkg::REG_IDX_WEIGHT: cfg_q.accel_weight  <= pwdata[15:0];
        default:                 cfg_q.sample_period <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tcf_pkg::REG_IDX_WEIGHT: prdata = {16'd0, cfg_q.accel_weight};
      default:                 prdata = {16'd0, cfg_q.sample_period};
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### design/tcf_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_mul: shared registered multiplier
// Signed 28-bit operand times unsigned 16-bit operand, product registered.
// ----------------------------------------------------------------------------
module tcf_mul (
  input  logic               clk_i,
  input  logic signed [27:0] a_i,
  input  logic        [15:0] b_i,
  output logic signed [44:0] p_o
);

  logic signed [44:0] p_q;
  logic signed [44:0] p_d;
  logic signed [16:0] b_s;

  assign b_s = {1'b0, b_i};
  assign p_d = 45'(a_i * b_s);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

### design/tcf_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_cordic: iterative vectoring CORDIC
// Forms atan(-ay/az) in 1/65536 degree, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module tcf_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  output logic               busy_o,
  output logic signed [23:0] angle_o
);

  localparam int unsigned NUM_STEPS =
    (CORDIC_STEPS > tcf_pkg::MAX_STEPS) ? tcf_pkg::MAX_STEPS : CORDIC_STEPS;
  localparam logic [4:0] LAST_IDX = 5'(NUM_STEPS - 1);

  tcf_pkg::cor_state_e state_q, state_d;

  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [24:0] z_q, z_d;
  logic        [4:0]  idx_q, idx_d;
  logic               pos_q, pos_d;
  logic signed [23:0] angle_q, angle_d;

  logic signed [16:0] ay_s, az_s, abs_y, abs_z;
  logic signed [33:0] xs, ys;
  logic signed [24:0] step_ang, z_clamp;

  assign ay_s  = 17'(accel_y_i);
  assign az_s  = 17'(accel_z_i);
  assign abs_y = ay_s[16] ? -ay_s : ay_s;
  assign abs_z = az_s[16] ? -az_s : az_s;

  assign xs       = x_q >>> idx_q;
  assign ys       = y_q >>> idx_q;
  assign step_ang = {3'b000, tcf_pkg::atan_lut(idx_q)};

  always_comb begin
    if (z_q < 0) begin
      z_clamp = '0;
    end else if (z_q > tcf_pkg::DEG90) begin
      z_clamp = tcf_pkg::DEG90;
    end else begin
      z_clamp = z_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcf_pkg::COR_IDLE: begin
        if (start_i) begin
          state_d = (abs_y == 0 || abs_z == 0) ? tcf_pkg::COR_FIN : tcf_pkg::COR_RUN;
        end
      end
      tcf_pkg::COR_RUN: begin
        if (idx_q == LAST_IDX) state_d = tcf_pkg::COR_FIN;
      end
      tcf_pkg::COR_FIN:  state_d = tcf_pkg::COR_IDLE;
      default:           state_d = tcf_pkg::COR_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    angle_d = angle_q;
    case (state_q)
      tcf_pkg::COR_IDLE: begin
        if (start_i) begin
          x_d   = {3'b000, abs_z, 14'd0};
          y_d   = {3'b000, abs_y, 14'd0};
          idx_d = '0;
          pos_d = accel_y_i[15] != accel_z_i[15];
          // degenerate inputs skip the rotations
          if (abs_y == 0) begin
            z_d = '0;
          end else if (abs_z == 0) begin
            z_d = tcf_pkg::DEG90;
          end else begin
            z_d = '0;
          end
        end
      end
      tcf_pkg::COR_RUN: begin
        if (y_q > 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + step_ang;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - step_ang;
        end
        idx_d = idx_q + 5'd1;
      end
      tcf_pkg::COR_FIN: begin
        angle_d = pos_q ? z_clamp[23:0] : -z_clamp[23:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcf_pkg::COR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    angle_q <= angle_d;
  end

  assign busy_o  = state_q != tcf_pkg::COR_IDLE;
  assign angle_o = angle_q;

endmodule
